// ===== hdl/prefixed_integer_text_parser_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the prefixed integer text parser
// Shared clocked assertion forms, disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef PREFIXED_INTEGER_TEXT_PARSER_CORE_ASSERT_SVH
`define PREFIXED_INTEGER_TEXT_PARSER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PITP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PITP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/pitp_pkg.sv =====
// ----------------------------------------------------------------------------
// pitp_pkg
// Types, character codes and digit decoding for the integer text parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pitp_pkg;

    localparam int CHAR_WIDTH  = 8;
    localparam int VALUE_WIDTH = 64;
    localparam int NARROW_WIDTH = 32;
    localparam int DIGIT_WIDTH = 5;
    localparam int CFG_ADDR_WIDTH = 1;
    localparam int CFG_DATA_WIDTH = 1;

    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_IDX_WIDE_MODE = 1'b0;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_IDX_DOUBLE_ZERO = 1'b1;

    localparam logic [CHAR_WIDTH-1:0] CH_NUL    = 8'h00;
    localparam logic [CHAR_WIDTH-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_WIDTH-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CHAR_WIDTH-1:0] CH_DOLLAR = 8'h24;
    localparam logic [CHAR_WIDTH-1:0] CH_0      = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CH_9      = 8'h39;
    localparam logic [CHAR_WIDTH-1:0] CH_UA     = 8'h41;
    localparam logic [CHAR_WIDTH-1:0] CH_UF     = 8'h46;
    localparam logic [CHAR_WIDTH-1:0] CH_LA     = 8'h61;
    localparam logic [CHAR_WIDTH-1:0] CH_LF     = 8'h66;
    localparam logic [CHAR_WIDTH-1:0] CH_UX     = 8'h58;
    localparam logic [CHAR_WIDTH-1:0] CH_LX     = 8'h78;
    localparam logic [CHAR_WIDTH-1:0] CH_UB     = 8'h42;
    localparam logic [CHAR_WIDTH-1:0] CH_LB     = 8'h62;
    localparam logic [CHAR_WIDTH-1:0] CH_UK     = 8'h4B;
    localparam logic [CHAR_WIDTH-1:0] CH_LK     = 8'h6B;
    localparam logic [CHAR_WIDTH-1:0] CH_UM     = 8'h4D;
    localparam logic [CHAR_WIDTH-1:0] CH_LM     = 8'h6D;

    // Digit code for bytes that are no hex digit at all.
    localparam logic [DIGIT_WIDTH-1:0] DIGIT_NONE = 5'd16;

    localparam int SHIFT_KILO = 10;
    localparam int SHIFT_MEGA = 20;

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_SIGNED = 3'd1,
        PH_ZERO   = 3'd2,
        PH_DIGITS = 3'd3,
        PH_DONE   = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        RX_DEC = 2'd0,
        RX_HEX = 2'd1,
        RX_BIN = 2'd2,
        RX_OCT = 2'd3
    } radix_t;

    // Hex digit value of a byte, or DIGIT_NONE.
    function automatic logic [DIGIT_WIDTH-1:0] digit_of(input logic [CHAR_WIDTH-1:0] c);
        logic [DIGIT_WIDTH-1:0] d;
        d = DIGIT_NONE;
        if (c >= CH_0 && c <= CH_9)
            d = DIGIT_WIDTH'(c - CH_0);
        else if (c >= CH_UA && c <= CH_UF)
            d = DIGIT_WIDTH'(c - CH_UA + 8'd10);
        else if (c >= CH_LA && c <= CH_LF)
            d = DIGIT_WIDTH'(c - CH_LA + 8'd10);
        return d;
    endfunction

    // True when the digit code is below the base of the radix.
    function automatic logic digit_fits(input logic [DIGIT_WIDTH-1:0] d, input radix_t rx);
        logic ok;
        case (rx)
            RX_DEC:  ok = (d < 5'd10);
            RX_HEX:  ok = (d < 5'd16);
            RX_BIN:  ok = (d < 5'd2);
            RX_OCT:  ok = (d < 5'd8);
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

// ===== hdl/prefixed_integer_text_parser_core.sv =====
// ----------------------------------------------------------------------------
// prefixed_integer_text_parser_core
// Parses a signed integer text with radix prefix and k/m suffix, one byte
// per beat, and emits one value per string.
// ----------------------------------------------------------------------------
//  Channel   | Direction | Beat contents
//  s_axis    | in        | tdata: char_code[7:0]; tlast: last_char
//  m_axis    | out       | tdata: value[63:0]; tuser: looks_decimal
//  cfg       | in        | index 0: wide_mode, index 1: double_zero_is_decimal
//
//  Sustained rate is one byte beat per cycle; the beat that ends a string
//  passes the input register, then the result register, before its result appears.
//  The byte update is one 64-bit shift-add of the accumulator per cycle.
//  Reset clears the parse state and sets wide_mode to 1 and
//  double_zero_is_decimal to 0. Bytes keep flowing while a result waits;
//  only a string end stalls behind an untaken result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "prefixed_integer_text_parser_core_assert.svh"

module prefixed_integer_text_parser_core
    import pitp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [CHAR_WIDTH-1:0]     s_axis_tdata,   // [7:0] char_code
    input  logic                      s_axis_tlast,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [VALUE_WIDTH-1:0]    m_axis_tdata,   // [63:0] value
    output logic                      m_axis_tuser,   // [0] looks_decimal
    input  logic                      cfg_we,
    input  logic [CFG_ADDR_WIDTH-1:0] cfg_addr,
    input  logic [CFG_DATA_WIDTH-1:0] cfg_wdata
);

    logic                   wide_mode_reg;
    logic                   double_zero_reg;

    logic                   in_valid_reg;
    logic [CHAR_WIDTH-1:0]  in_char_reg;
    logic                   in_last_reg;

    phase_t                 phase_reg, phase_next;
    radix_t                 radix_reg, radix_next;
    logic                   neg_reg, neg_next;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    logic                   dec_reg, dec_next;

    logic                   out_valid_reg;
    logic [VALUE_WIDTH-1:0] out_value_reg, out_value_next;
    logic                   out_dec_reg;

    logic                   ends_string;
    logic                   advance;
    radix_t                 step_radix;
    logic [DIGIT_WIDTH-1:0] step_digit;
    logic                   step_is_digit;
    logic [VALUE_WIDTH-1:0] acc_scaled;
    logic [VALUE_WIDTH-1:0] step_acc;
    logic [VALUE_WIDTH-1:0] signed_acc;
    logic                   is_dec_char;

    assign ends_string   = (in_char_reg == CH_NUL) || in_last_reg;
    assign advance       = in_valid_reg && (!ends_string || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tuser  = out_dec_reg;

    // The radix a digit byte is judged against depends on the phase and, in the digits phase, on the stored radix.
    always_comb
    begin
        case (phase_reg)
            PH_ZERO:   step_radix = RX_OCT;
            PH_DIGITS: step_radix = radix_reg;
            default:   step_radix = RX_DEC;
        endcase
    end

    assign step_digit    = digit_of(in_char_reg);
    assign step_is_digit = digit_fits(step_digit, step_radix);
    assign is_dec_char   = (in_char_reg >= CH_0) && (in_char_reg <= CH_9);

    always_comb
    begin
        case (step_radix)
            RX_DEC:  acc_scaled = (acc_reg << 3) + (acc_reg << 1);
            RX_HEX:  acc_scaled = acc_reg << 4;
            RX_BIN:  acc_scaled = acc_reg << 1;
            RX_OCT:  acc_scaled = acc_reg << 3;
            default: acc_scaled = acc_reg;
        endcase
    end

    // Accumulator after a digit byte, or after the suffix check on a non-digit.
    always_comb
    begin
        step_acc = acc_reg;
        if (step_is_digit)
            step_acc = acc_scaled + VALUE_WIDTH'(step_digit);
        else if (acc_reg != '0)
        begin
            if (in_char_reg == CH_UM || in_char_reg == CH_LM)
                step_acc = acc_reg << SHIFT_MEGA;
            else if (in_char_reg == CH_UK || in_char_reg == CH_LK)
                step_acc = acc_reg << SHIFT_KILO;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        radix_next = radix_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        dec_next   = dec_reg;
        if (in_char_reg != CH_NUL)
        begin
            case (phase_reg)
                PH_START, PH_SIGNED:
                begin
                    if (phase_reg == PH_START && in_char_reg == CH_MINUS)
                    begin
                        neg_next   = 1'b1;
                        phase_next = PH_SIGNED;
                    end
                    else if (phase_reg == PH_START && in_char_reg == CH_PLUS)
                        phase_next = PH_SIGNED;
                    else if (in_char_reg == CH_0)
                    begin
                        phase_next = PH_ZERO;
                        dec_next   = 1'b1;
                    end
                    else if (in_char_reg == CH_DOLLAR)
                    begin
                        radix_next = RX_HEX;
                        dec_next   = 1'b0;
                        phase_next = PH_DIGITS;
                    end
                    else
                    begin
                        radix_next = RX_DEC;
                        dec_next   = is_dec_char;
                        acc_next   = step_acc;
                        phase_next = step_is_digit ? PH_DIGITS : PH_DONE;
                    end
                end
                PH_ZERO:
                begin
                    phase_next = PH_DIGITS;
                    dec_next   = 1'b0;
                    if (in_char_reg == CH_UX || in_char_reg == CH_LX)
                        radix_next = RX_HEX;
                    else if (in_char_reg == CH_UB || in_char_reg == CH_LB)
                        radix_next = RX_BIN;
                    else if (in_char_reg == CH_0 && double_zero_reg)
                    begin
                        radix_next = RX_DEC;
                        dec_next   = 1'b1;
                    end
                    else
                    begin
                        radix_next = RX_OCT;
                        acc_next   = step_acc;
                        if (!step_is_digit)
                            phase_next = PH_DONE;
                    end
                end
                PH_DIGITS:
                begin
                    acc_next = step_acc;
                    if (!step_is_digit)
                        phase_next = PH_DONE;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        signed_acc     = neg_next ? (VALUE_WIDTH'(0) - acc_next) : acc_next;
        out_value_next = signed_acc;
        if (!wide_mode_reg)
            out_value_next = {{(VALUE_WIDTH-NARROW_WIDTH){1'b0}},
                              signed_acc[NARROW_WIDTH-1:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_mode_reg   <= 1'b1;
            double_zero_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_IDX_WIDE_MODE:   wide_mode_reg   <= cfg_wdata[0];
                CFG_IDX_DOUBLE_ZERO: double_zero_reg <= cfg_wdata[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_char_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            radix_reg <= RX_DEC;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
            dec_reg   <= 1'b0;
        end
        else if (advance)
        begin
            if (ends_string)
            begin
                phase_reg <= PH_START;
                radix_reg <= RX_DEC;
                neg_reg   <= 1'b0;
                acc_reg   <= '0;
                dec_reg   <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                radix_reg <= radix_next;
                neg_reg   <= neg_next;
                acc_reg   <= acc_next;
                dec_reg   <= dec_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && ends_string)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && ends_string)
        begin
            out_value_reg <= out_value_next;
            out_dec_reg   <= dec_next;
        end
    end

    `PITP_ASSERT_NEXT(a_clear_after_end, clk, rst_n, advance && ends_string,
        phase_reg == PH_START && acc_reg == '0 && !neg_reg,
        "parse state not cleared after string end")
    `PITP_ASSERT_SAME(a_start_is_clean, clk, rst_n, phase_reg == PH_START,
        !neg_reg && acc_reg == '0 && !dec_reg,
        "start phase holds leftover state")
    `PITP_ASSERT_SAME(a_zero_phase, clk, rst_n, phase_reg == PH_ZERO,
        acc_reg == '0 && dec_reg,
        "leading zero phase with nonzero accumulator")
    `PITP_ASSERT_SAME(a_narrow_mask, clk, rst_n, m_axis_tvalid && !wide_mode_reg,
        m_axis_tdata[VALUE_WIDTH-1:NARROW_WIDTH] == '0,
        "narrow mode result has upper bits set")

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer text parser testbench
// Streams text numbers into the parser one byte per beat. A predictor in the
// driver follows every accepted byte and keeps the value each finished string
// should produce. The monitor checks each result beat against the oldest one.
// Phases change the width and double-zero registers and the idle patterns of
// both sides. One phase holds the result side off long enough to stall the
// input.
// ----------------------------------------------------------------------------

module testbench;

    import pitp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_BYTES = 130;
    localparam int HOLD_CYCLES = 300;
    localparam logic [4:0] NO_DIGIT = 5'd31;

    typedef struct packed {
        logic [CHAR_WIDTH-1:0] code;
        logic                  last;
    } char_beat_t;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        logic                   looks_dec;
    } parse_result_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [CHAR_WIDTH-1:0]     s_axis_tdata = '0;   // [7:0] char_code
    logic                      s_axis_tlast = 1'b0; // last_char
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [VALUE_WIDTH-1:0]    m_axis_tdata;        // [63:0] value
    logic                      m_axis_tuser;        // [0] looks_decimal
    logic                      cfg_we = 1'b0;
    logic [CFG_ADDR_WIDTH-1:0] cfg_addr = '0;
    logic [CFG_DATA_WIDTH-1:0] cfg_wdata = '0;

    char_beat_t    byte_q[$];
    parse_result_t parse_q[$];
    logic [7:0]    text_buf[$];
    string         noise_chars = "+-0$xXbBkKmM19fF";

    // Predictor state and its copy of the registers.
    phase_t                 scan_phase;
    radix_t                 scan_radix;
    logic                   scan_neg;
    logic [VALUE_WIDTH-1:0] scan_acc;
    logic                   scan_dec;
    logic                   mdl_wide = 1'b1;
    logic                   mdl_dz = 1'b0;

    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic want_hold = 1'b0;
    logic hold_off = 1'b0;
    int   fault_count = 0;
    int   cycle_count = 0;

    prefixed_integer_text_parser_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic logic [VALUE_WIDTH-1:0] base_of(input radix_t rx);
        case (rx)
            RX_HEX:  return 64'd16;
            RX_BIN:  return 64'd2;
            RX_OCT:  return 64'd8;
            default: return 64'd10;
        endcase
    endfunction

    function automatic logic [4:0] digit_in_radix(input logic [7:0] c, input radix_t rx);
        logic [4:0] d;
        if (c >= CH_0 && c <= CH_9)
            d = 5'(c - CH_0);
        else if (c >= CH_UA && c <= CH_UF)
            d = 5'(c - CH_UA + 8'd10);
        else if (c >= CH_LA && c <= CH_LF)
            d = 5'(c - CH_LA + 8'd10);
        else
            d = NO_DIGIT;
        if (d != NO_DIGIT && 64'(d) >= base_of(rx))
            d = NO_DIGIT;
        return d;
    endfunction

    task automatic clear_scan();
        scan_phase = PH_START;
        scan_radix = RX_DEC;
        scan_neg = 1'b0;
        scan_acc = '0;
        scan_dec = 1'b0;
    endtask

    task automatic absorb_digit(input logic [7:0] c);
        logic [4:0] d;
        d = digit_in_radix(c, scan_radix);
        if (d != NO_DIGIT)
        begin
            scan_acc = scan_acc * base_of(scan_radix) + 64'(d);
        end
        else
        begin
            // The terminating byte may scale a nonzero value.
            if (scan_acc != '0)
            begin
                if (c == CH_UM || c == CH_LM)
                    scan_acc = scan_acc << SHIFT_MEGA;
                else if (c == CH_UK || c == CH_LK)
                    scan_acc = scan_acc << SHIFT_KILO;
            end
            scan_phase = PH_DONE;
        end
    endtask

    task automatic absorb_first(input logic [7:0] c);
        if (c == CH_0)
        begin
            scan_phase = PH_ZERO;
            scan_dec = 1'b1;
        end
        else if (c == CH_DOLLAR)
        begin
            scan_radix = RX_HEX;
            scan_dec = 1'b0;
            scan_phase = PH_DIGITS;
        end
        else
        begin
            scan_radix = RX_DEC;
            scan_dec = (c >= CH_0 && c <= CH_9);
            scan_phase = PH_DIGITS;
            absorb_digit(c);
        end
    endtask

    task automatic absorb_char(input logic [7:0] c);
        case (scan_phase)
            PH_START:
            begin
                if (c == CH_MINUS)
                begin
                    scan_neg = 1'b1;
                    scan_phase = PH_SIGNED;
                end
                else if (c == CH_PLUS)
                    scan_phase = PH_SIGNED;
                else
                    absorb_first(c);
            end
            PH_SIGNED:
                absorb_first(c);
            PH_ZERO:
            begin
                scan_phase = PH_DIGITS;
                if (c == CH_LX || c == CH_UX)
                begin
                    scan_radix = RX_HEX;
                    scan_dec = 1'b0;
                end
                else if (c == CH_LB || c == CH_UB)
                begin
                    scan_radix = RX_BIN;
                    scan_dec = 1'b0;
                end
                else if (c == CH_0 && mdl_dz)
                begin
                    scan_radix = RX_DEC;
                    scan_dec = 1'b1;
                end
                else
                begin
                    scan_radix = RX_OCT;
                    scan_dec = 1'b0;
                    absorb_digit(c);
                end
            end
            PH_DIGITS:
                absorb_digit(c);
            default:
                ;
        endcase
    endtask

    task automatic predict_parse(input logic [7:0] c, input logic last);
        parse_result_t r;
        if (c != CH_NUL)
            absorb_char(c);
        if (c == CH_NUL || last)
        begin
            r.value = scan_neg ? (64'd0 - scan_acc) : scan_acc;
            if (!mdl_wide)
                r.value[VALUE_WIDTH-1:NARROW_WIDTH] = '0;
            r.looks_dec = scan_dec;
            parse_q.push_back(r);
            clear_scan();
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver and monitor
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : drive_proc
        logic took;
        if (rst_n)
        begin
            took = s_axis_tvalid && s_axis_tready;
            if (took)
            begin
                predict_parse(s_axis_tdata, s_axis_tlast);
                void'(byte_q.pop_front());
            end
            if (s_axis_tvalid && !took)
                ;
            else if (byte_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= byte_q[0].code;
                s_axis_tlast <= byte_q[0].last;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    task automatic note_fault(input string what, input logic [63:0] want, input logic [63:0] got);
        if (fault_count < 10)
            $display("mismatch on %s: expected %h, got %h", what, want, got);
        fault_count++;
    endtask

    always @(posedge clk)
    begin : watch_proc
        parse_result_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (parse_q.size() == 0)
                begin
                    note_fault("unexpected result value", '0, m_axis_tdata);
                end
                else
                begin
                    want = parse_q.pop_front();
                    if (m_axis_tdata !== want.value)
                        note_fault("value", want.value, m_axis_tdata);
                    if (m_axis_tuser !== want.looks_dec)
                        note_fault("looks_decimal", 64'(want.looks_dec), 64'(m_axis_tuser));
                end
            end
            m_axis_tready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // The long hold-off runs on its own so the sender keeps offering bytes.
    initial
    begin
        wait (want_hold);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endtask

    // Moves the buffered text into the beat queue, ended by a zero byte or
    // by the last flag on its final byte.
    task automatic flush_text(input bit nul_end);
        char_beat_t b;
        if (text_buf.size() == 0)
            nul_end = 1'b1;
        foreach (text_buf[i])
        begin
            b.code = text_buf[i];
            b.last = !nul_end && (i == text_buf.size() - 1);
            byte_q.push_back(b);
        end
        if (nul_end)
        begin
            b.code = CH_NUL;
            b.last = 1'($urandom_range(0, 1));
            byte_q.push_back(b);
        end
        text_buf.delete();
    endtask

    function automatic logic [7:0] noise_byte();
        if ($urandom_range(0, 1))
            return noise_chars[$urandom_range(0, noise_chars.len() - 1)];
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic logic [7:0] random_digit(input radix_t rx);
        int d;
        case (rx)
            RX_HEX:
            begin
                d = $urandom_range(0, 15);
                if (d < 10)
                    return CH_0 + 8'(d);
                return ($urandom_range(0, 1) ? CH_UA : CH_LA) + 8'(d - 10);
            end
            RX_BIN:  return CH_0 + 8'($urandom_range(0, 1));
            RX_OCT:  return CH_0 + 8'($urandom_range(0, 7));
            default: return CH_0 + 8'($urandom_range(0, 9));
        endcase
    endfunction

    task automatic push_random_text();
        radix_t rx;
        int     n;
        int     pick;
        if ($urandom_range(0, 99) < 15)
        begin
            n = $urandom_range(0, 8);
            repeat (n) text_buf.push_back(noise_byte());
        end
        else
        begin
            pick = $urandom_range(0, 3);
            if (pick == 0)
                text_buf.push_back(CH_MINUS);
            else if (pick == 1)
                text_buf.push_back(CH_PLUS);
            rx = RX_DEC;
            case ($urandom_range(0, 7))
                0: begin put_str("0x"); rx = RX_HEX; end
                1: begin put_str("0X"); rx = RX_HEX; end
                2: begin put_str("$"); rx = RX_HEX; end
                3: begin put_str("0b"); rx = RX_BIN; end
                4: begin put_str("0B"); rx = RX_BIN; end
                5: begin put_str("0"); rx = RX_OCT; end
                6: begin put_str("00"); rx = mdl_dz ? RX_DEC : RX_OCT; end
                default: ;
            endcase
            // Now and then a run long enough to wrap the accumulator.
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 24) : $urandom_range(0, 6);
            repeat (n) text_buf.push_back(random_digit(rx));
            case ($urandom_range(0, 5))
                0: text_buf.push_back(CH_LK);
                1: text_buf.push_back(CH_UK);
                2: text_buf.push_back(CH_LM);
                3: text_buf.push_back(CH_UM);
                default: ;
            endcase
            if ($urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 3);
                repeat (n) text_buf.push_back(noise_byte());
            end
        end
        flush_text(1'($urandom_range(0, 1)));
    endtask

    task automatic write_reg(input logic [CFG_ADDR_WIDTH-1:0] idx, input logic val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_IDX_WIDE_MODE)
            mdl_wide = val;
        else
            mdl_dz = val;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (byte_q.size() != 0 || s_axis_tvalid || parse_q.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            1:       begin send_idle_pct = 60; recv_stall_pct = 0; end
            2:       begin send_idle_pct = 0; recv_stall_pct = 60; end
            3:       begin send_idle_pct = 31; recv_stall_pct = 31; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
        endcase
    endtask

    initial
    begin : main_proc
        logic [2:0] p;
        clear_scan();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        write_reg(CFG_IDX_WIDE_MODE, 1'b1);
        write_reg(CFG_IDX_DOUBLE_ZERO, 1'b0);
        @(negedge clk);
        set_idling(0);
        flush_text(1'b1);                      // empty string
        put_str("-");    flush_text(1'b0);     // sign alone
        put_str("0");    flush_text(1'b0);     // lone zero is decimal
        put_str("$k");   flush_text(1'b0);     // prefix without digits, no suffix on zero
        put_str("-0x1M"); flush_text(1'b0);
        put_str("+0B1k"); flush_text(1'b1);
        put_str("017");  flush_text(1'b0);
        text_buf.push_back(8'hFF);             // high byte as invalid first digit
        put_str("1");    flush_text(1'b0);
        put_str("009");  flush_text(1'b0);     // octal, nine stops it
        put_str("9m");   flush_text(1'b0);
        wait_drained();

        // Narrow values and double zero as decimal.
        write_reg(CFG_IDX_WIDE_MODE, 1'b0);
        write_reg(CFG_IDX_DOUBLE_ZERO, 1'b1);
        @(negedge clk);
        put_str("-0012"); flush_text(1'b0);
        put_str("-1");    flush_text(1'b1);
        wait_drained();

        for (int k = 0; k < 8; k++)
        begin
            p = 3'(k);
            write_reg(CFG_IDX_WIDE_MODE, p[0]);
            write_reg(CFG_IDX_DOUBLE_ZERO, p[1] ^ p[2]);
            @(negedge clk);
            set_idling(k / 2);
            while (byte_q.size() < PHASE_BYTES)
                push_random_text();
            wait_drained();
        end

        // Result side held off while bytes keep coming.
        write_reg(CFG_IDX_WIDE_MODE, 1'b1);
        write_reg(CFG_IDX_DOUBLE_ZERO, 1'b0);
        @(negedge clk);
        set_idling(0);
        while (byte_q.size() < PHASE_BYTES)
            push_random_text();
        want_hold = 1'b1;
        wait_drained();

        repeat (8) @(negedge clk);
        if (fault_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/pitp_pkg.sv
hdl/prefixed_integer_text_parser_core.sv
test/testbench.sv
